### design/rrsd_pkg.sv
// ----------------------------------------------------------------------------
// rrsd_pkg
// Shared widths, codes, types and helpers for the rounded rectangle signed
// distance pipeline.
// ----------------------------------------------------------------------------
package rrsd_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int FRAC_BITS      = 4;
  localparam int DIST_WIDTH     = 22;
  localparam int REGION_WIDTH   = 4;
  localparam int CFG_IDX_WIDTH  = 3;

  localparam int RAD_WIDTH      = COORD_WIDTH - 1;
  localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
  localparam int PRE_WIDTH      = DIFF_WIDTH + 1;
  localparam int LIN_WIDTH      = PRE_WIDTH + FRAC_BITS;
  localparam int SQ_WIDTH       = 2 * DIFF_WIDTH;
  localparam int SUMSQ_WIDTH    = SQ_WIDTH + 1;
  localparam int RADICAND_WIDTH = SUMSQ_WIDTH + 2 * FRAC_BITS;
  localparam int ROOT_WIDTH     = (RADICAND_WIDTH + 1) / 2;
  localparam int RAD_PAD_WIDTH  = 2 * ROOT_WIDTH;
  localparam int REM_WIDTH      = ROOT_WIDTH + 2;

  // final adder is wide enough for root + offset and for the output itself
  localparam int FIN_BASE  = (ROOT_WIDTH + 1 > LIN_WIDTH) ? ROOT_WIDTH + 1 : LIN_WIDTH;
  localparam int FIN_WIDTH = ((FIN_BASE > DIST_WIDTH) ? FIN_BASE : DIST_WIDTH) + 1;

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
  localparam logic [DIST_WIDTH-1:0] DIST_MIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

  localparam logic [REGION_WIDTH-1:0] REGION_BOTTOM = 4'd1;
  localparam logic [REGION_WIDTH-1:0] REGION_LEFT   = 4'd3;
  localparam logic [REGION_WIDTH-1:0] REGION_INNER  = 4'd4;
  localparam logic [REGION_WIDTH-1:0] REGION_RIGHT  = 4'd5;
  localparam logic [REGION_WIDTH-1:0] REGION_TOP    = 4'd7;
  localparam logic [REGION_WIDTH-1:0] REGION_LAST   = 4'd8;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_LEFT_X,
    CFG_RIGHT_X,
    CFG_BOTTOM_Y,
    CFG_TOP_Y,
    CFG_RADIUS
  } cfg_idx_e;

  // position of a coordinate against its pair of poles
  typedef enum logic [1:0] {
    POS_BELOW,
    POS_BETWEEN,
    POS_ABOVE
  } pos_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] left_x;
    logic signed [COORD_WIDTH-1:0] right_x;
    logic signed [COORD_WIDTH-1:0] bottom_y;
    logic signed [COORD_WIDTH-1:0] top_y;
    logic [RAD_WIDTH-1:0]          radius;
  } rrsd_cfg_t;

  // travels beside the radicand through the square root stages
  typedef struct packed {
    logic                        corner;
    logic [REGION_WIDTH-1:0]     region;
    logic signed [LIN_WIDTH-1:0] offset;
  } rrsd_side_t;

  function automatic logic signed [DIFF_WIDTH-1:0] sdiff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  endfunction

  function automatic logic [REGION_WIDTH-1:0] region_code(
    input pos_e row,
    input pos_e col
  );
    logic [REGION_WIDTH-1:0] r;
    logic [REGION_WIDTH-1:0] c;
    r = REGION_WIDTH'(row);
    c = REGION_WIDTH'(col);
    return (r << 1) + r + c;
  endfunction

endpackage

### design/rounded_rect_signed_distance.sv
// ----------------------------------------------------------------------------
// rounded_rect_signed_distance
// Signed distance from a point to a rounded rectangle, with region report.
// ----------------------------------------------------------------------------
// Takes one point per clock, unless the output stalls, and returns its
// signed distance (sixteenths, truncated) to the rectangle between the
// configured poles inflated by the radius, together with its region
// (row*3 + col). The pipeline accepts a new request every cycle unless the
// output stalls; it is built of the front end, the square root that
// resolves one result bit per stage, and the output register. A stall on
// the output holds the whole pipeline in place, so nothing is lost or
// repeated. Poles and radius are plain registers read by the pipeline every
// cycle: write them only while no request is in flight. The configuration
// port is always ready and ignores indexes past the radius.
// ----------------------------------------------------------------------------
module rounded_rect_signed_distance import rrsd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [DIST_WIDTH-1:0]  distance_o,
  output logic [REGION_WIDTH-1:0]       region_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i
);

  rrsd_cfg_t                cfg;
  logic                     adv;
  logic                     fr_valid;
  logic [RAD_PAD_WIDTH-1:0] fr_radicand;
  rrsd_side_t               fr_side;
  logic                     sq_valid;
  logic [ROOT_WIDTH-1:0]    sq_root;
  rrsd_side_t               sq_side;

  // whole pipeline moves unless the result register is full and stalled
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  rrsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rrsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (in_valid_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .cfg_i      (cfg),
    .valid_o    (fr_valid),
    .radicand_o (fr_radicand),
    .side_o     (fr_side)
  );

  rrsd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (fr_valid),
    .radicand_i (fr_radicand),
    .side_i     (fr_side),
    .valid_o    (sq_valid),
    .root_o     (sq_root),
    .side_o     (sq_side)
  );

  // output stage: root plus offset (offset already holds -r for corners)
  logic signed [FIN_WIDTH-1:0]            fin_off;
  logic signed [FIN_WIDTH-1:0]            fin_root;
  logic signed [FIN_WIDTH-1:0]            fin_sum;
  logic [FIN_WIDTH-DIST_WIDTH:0]          fin_top;
  logic                                   out_valid_q;
  logic [DIST_WIDTH-1:0]                  dist_q, dist_d;
  logic [REGION_WIDTH-1:0]                region_q;

  assign fin_off  = FIN_WIDTH'(sq_side.offset);
  assign fin_root = $signed(FIN_WIDTH'(sq_root));
  assign fin_sum  = fin_off + (sq_side.corner ? fin_root : $signed(FIN_WIDTH'(0)));
  assign fin_top  = fin_sum[FIN_WIDTH-1:DIST_WIDTH-1];

  always_comb begin
    if ((&fin_top) || !(|fin_top)) begin
      dist_d = fin_sum[DIST_WIDTH-1:0];
    end else if (fin_sum[FIN_WIDTH-1]) begin
      dist_d = DIST_MIN;
    end else begin
      dist_d = DIST_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q   <= dist_d;
      region_q <= sq_side.region;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sq_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign region_o    = region_q;

  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (region_o <= REGION_LAST))
    else $error("region code out of range");

  a_inner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (region_o == REGION_INNER) |-> (distance_o == '0))
    else $error("nonzero distance inside inner rectangle");

  // side distances are whole units, only corners carry a fraction
  a_side_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (region_o == REGION_BOTTOM || region_o == REGION_LEFT ||
                    region_o == REGION_RIGHT || region_o == REGION_TOP)
    |-> ((distance_o & DIST_WIDTH'((1 << FRAC_BITS) - 1)) == '0))
    else $error("fractional bits set on a side distance");

endmodule

### design/rrsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rrsd_cfg_regs
// Configuration register file: pole coordinates and radius, written by index.
// ----------------------------------------------------------------------------
module rrsd_cfg_regs import rrsd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [COORD_WIDTH-1:0]   cfg_data_i,
  output rrsd_cfg_t                cfg_o
);

  rrsd_cfg_t cfg_q;
  rrsd_cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEFT_X:   cfg_d.left_x   = cfg_data_i;
        CFG_RIGHT_X:  cfg_d.right_x  = cfg_data_i;
        CFG_BOTTOM_Y: cfg_d.bottom_y = cfg_data_i;
        CFG_TOP_Y:    cfg_d.top_y    = cfg_data_i;
        CFG_RADIUS:   cfg_d.radius   = cfg_data_i[RAD_WIDTH-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### design/rrsd_front.sv
// ----------------------------------------------------------------------------
// rrsd_front
// Three stages: classify against the poles, square the corner offsets and
// form the side distance, then sum and scale the radicand.
// ----------------------------------------------------------------------------
module rrsd_front import rrsd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  rrsd_cfg_t                     cfg_i,
  output logic                          valid_o,
  output logic [RAD_PAD_WIDTH-1:0]      radicand_o,
  output rrsd_side_t                    side_o
);

  logic signed [COORD_WIDTH-1:0] lx, rx, by, ty;

  assign lx = cfg_i.left_x;
  assign rx = cfg_i.right_x;
  assign by = cfg_i.bottom_y;
  assign ty = cfg_i.top_y;

  // stage 1: classification and axis differences
  logic                         s1_valid_q;
  pos_e                         s1_col_q, s1_col_d;
  pos_e                         s1_row_q, s1_row_d;
  logic signed [DIFF_WIDTH-1:0] s1_dl_q, s1_dr_q, s1_db_q, s1_dt_q;

  always_comb begin
    if (point_x_i < lx) begin
      s1_col_d = POS_BELOW;
    end else if (point_x_i < rx) begin
      s1_col_d = POS_BETWEEN;
    end else begin
      s1_col_d = POS_ABOVE;
    end
    if (point_y_i < by) begin
      s1_row_d = POS_BELOW;
    end else if (point_y_i < ty) begin
      s1_row_d = POS_BETWEEN;
    end else begin
      s1_row_d = POS_ABOVE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_col_q <= s1_col_d;
      s1_row_q <= s1_row_d;
      s1_dl_q  <= sdiff(lx, point_x_i);
      s1_dr_q  <= sdiff(point_x_i, rx);
      s1_db_q  <= sdiff(by, point_y_i);
      s1_dt_q  <= sdiff(point_y_i, ty);
    end
  end

  // stage 2: squares for corners, scaled side distance for the rest
  logic                         s2_valid_q;
  logic [SQ_WIDTH-1:0]          s2_sqx_q, s2_sqy_q;
  rrsd_side_t                   s2_side_q, s2_side_d;
  logic [DIFF_WIDTH-1:0]        s2_dx, s2_dy;
  logic signed [DIFF_WIDTH-1:0] s2_axis;
  logic                         s2_use_r;
  logic signed [PRE_WIDTH-1:0]  s2_pre;

  // in a corner the chosen difference is never negative, so it is a magnitude
  assign s2_dx = (s1_col_q == POS_BELOW) ? s1_dl_q : s1_dr_q;
  assign s2_dy = (s1_row_q == POS_BELOW) ? s1_db_q : s1_dt_q;

  always_comb begin
    s2_side_d.corner = (s1_col_q != POS_BETWEEN) && (s1_row_q != POS_BETWEEN);
    s2_side_d.region = region_code(s1_row_q, s1_col_q);
    s2_use_r = 1'b1;
    if (s2_side_d.corner) begin
      s2_axis = '0;
    end else if (s1_row_q == POS_BETWEEN && s1_col_q == POS_BELOW) begin
      s2_axis = s1_dl_q;
    end else if (s1_row_q == POS_BETWEEN && s1_col_q == POS_ABOVE) begin
      s2_axis = s1_dr_q;
    end else if (s1_row_q == POS_BELOW) begin
      s2_axis = s1_db_q;
    end else if (s1_row_q == POS_ABOVE) begin
      s2_axis = s1_dt_q;
    end else begin
      s2_axis  = '0;
      s2_use_r = 1'b0;
    end
    s2_pre = PRE_WIDTH'(s2_axis)
           - (s2_use_r ? $signed(PRE_WIDTH'(cfg_i.radius)) : $signed(PRE_WIDTH'(0)));
    s2_side_d.offset = LIN_WIDTH'(s2_pre) <<< FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sqx_q  <= SQ_WIDTH'(s2_dx) * SQ_WIDTH'(s2_dx);
      s2_sqy_q  <= SQ_WIDTH'(s2_dy) * SQ_WIDTH'(s2_dy);
      s2_side_q <= s2_side_d;
    end
  end

  // stage 3: sum of squares scaled by 2^(2*FRAC_BITS)
  logic                     s3_valid_q;
  logic [RAD_PAD_WIDTH-1:0] s3_rad_q;
  rrsd_side_t               s3_side_q;
  logic [SUMSQ_WIDTH-1:0]   s3_sum;

  assign s3_sum = SUMSQ_WIDTH'(s2_sqx_q) + SUMSQ_WIDTH'(s2_sqy_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_rad_q  <= RAD_PAD_WIDTH'(s3_sum) << (2 * FRAC_BITS);
      s3_side_q <= s2_side_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  assign valid_o    = s3_valid_q;
  assign radicand_o = s3_rad_q;
  assign side_o     = s3_side_q;

endmodule

### design/rrsd_sqrt.sv
// ----------------------------------------------------------------------------
// rrsd_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rrsd_sqrt import rrsd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [RAD_PAD_WIDTH-1:0] radicand_i,
  input  rrsd_side_t               side_i,
  output logic                     valid_o,
  output logic [ROOT_WIDTH-1:0]    root_o,
  output rrsd_side_t               side_o
);

  logic                     valid_q [ROOT_WIDTH];
  logic [REM_WIDTH-1:0]     rem_q   [ROOT_WIDTH];
  logic [ROOT_WIDTH-1:0]    root_q  [ROOT_WIDTH];
  logic [RAD_PAD_WIDTH-1:0] rad_q   [ROOT_WIDTH];
  rrsd_side_t               side_q  [ROOT_WIDTH];

  for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
    logic                     valid_in;
    logic [REM_WIDTH-1:0]     rem_in;
    logic [ROOT_WIDTH-1:0]    root_in;
    logic [RAD_PAD_WIDTH-1:0] rad_in;
    rrsd_side_t               side_in;
    logic [REM_WIDTH-1:0]     rem_sh;
    logic [REM_WIDTH-1:0]     trial;
    logic                     take;

    if (k == 0) begin : g_head
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign rad_in   = radicand_i;
      assign side_in  = side_i;
    end else begin : g_body
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign rad_in   = rad_q[k-1];
      assign side_in  = side_q[k-1];
    end

    // bring down the next two radicand bits, try root*4 + 1
    assign rem_sh = {rem_in[REM_WIDTH-3:0], rad_in[RAD_PAD_WIDTH-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[ROOT_WIDTH-2:0], take};
        rad_q[k]  <= {rad_in[RAD_PAD_WIDTH-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end
  end

  assign valid_o = valid_q[ROOT_WIDTH-1];
  assign root_o  = root_q[ROOT_WIDTH-1];
  assign side_o  = side_q[ROOT_WIDTH-1];

  // a frozen pipeline must not drop or alter the item at its end
  a_hold_on_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o) && $stable(root_o) && $stable(side_o))
    else $error("sqrt pipeline moved while frozen");

endmodule

### sim/rounded_rect_signed_distance_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rounded_rect_signed_distance_tb
// Self-checking bench for the rounded rectangle signed distance pipeline.
// A short table of directed requests and register writes runs first, then
// random phases, each with its own poles and radius. Every accepted point is
// scored against its typed table entry or an in-bench distance calculator,
// and results are matched in order. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module rounded_rect_signed_distance_tb;
  import rrsd_pkg::*;

  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          DRAIN_CYCLES = 40;   // pipeline is 26 deep
  localparam int          PHASES       = 11;
  localparam int          PHASE_POINTS = 60;
  localparam int          ROOT_BITS    = 24;
  localparam longint      DIST_HI      = (64'sd1 <<< (DIST_WIDTH - 1)) - 1;
  localparam longint      DIST_LO      = -DIST_HI - 1;
  localparam int          NUM_ROWS     = 26;

  localparam logic [CFG_IDX_WIDTH-1:0] IDX_SPARE_LO = CFG_IDX_WIDTH'(CFG_RADIUS + 1);
  localparam logic [CFG_IDX_WIDTH-1:0] IDX_SPARE_HI = '1;

  localparam logic [REGION_WIDTH-1:0] REGION_LOWER_LEFT  = 4'd0;
  localparam logic [REGION_WIDTH-1:0] REGION_LOWER_RIGHT = 4'd2;
  localparam logic [REGION_WIDTH-1:0] REGION_UPPER_LEFT  = 4'd6;
  localparam logic [REGION_WIDTH-1:0] REGION_UPPER_RIGHT = REGION_LAST;

  localparam bit ROW_POINT = 1'b0;
  localparam bit ROW_WRITE = 1'b1;
  localparam bit PREDICTED = 1'b0;
  localparam bit TYPED     = 1'b1;

  typedef struct packed {
    logic signed [DIST_WIDTH-1:0] distance;
    logic [REGION_WIDTH-1:0]      region;
  } dist_result_t;

  // one line of the directed table: a point request or a register write
  typedef struct packed {
    logic                         is_write;
    logic [CFG_IDX_WIDTH-1:0]     reg_idx;
    logic [COORD_WIDTH-1:0]       a;
    logic [COORD_WIDTH-1:0]       b;
    logic                         typed;
    logic signed [DIST_WIDTH-1:0] distance;
    logic [REGION_WIDTH-1:0]      region;
  } table_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [COORD_WIDTH-1:0] point_x = '0;
  logic signed [COORD_WIDTH-1:0] point_y = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [DIST_WIDTH-1:0]  distance;
  logic [REGION_WIDTH-1:0]       region;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]      cfg_index = '0;
  logic [COORD_WIDTH-1:0]        cfg_data = '0;

  // shadow of the block's registers
  logic signed [COORD_WIDTH-1:0] left_pole = '0;
  logic signed [COORD_WIDTH-1:0] right_pole = '0;
  logic signed [COORD_WIDTH-1:0] bottom_pole = '0;
  logic signed [COORD_WIDTH-1:0] top_pole = '0;
  logic [RAD_WIDTH-1:0]          radius = '0;

  dist_result_t pending_results[$];
  table_row_t   directed_rows[NUM_ROWS];
  int           fail_count = 0;
  int           cycle_count = 0;
  int unsigned  stall_run = 0;
  bit           steady = 1'b0;

  rounded_rect_signed_distance u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .distance_o  (distance),
    .region_o    (region),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rounded_rect_signed_distance_tb NOT OK");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned dice;
    dice = $urandom_range(99);
    if (dice < 60) return 0;
    if (dice < 88) return $urandom_range(3, 1);
    if (dice < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // coordinates cluster around the two poles so every region gets hit
  function automatic logic signed [COORD_WIDTH-1:0] pick_coord(
    input logic signed [COORD_WIDTH-1:0] lo,
    input logic signed [COORD_WIDTH-1:0] hi
  );
    int unsigned dice;
    int          off;
    dice = $urandom_range(99);
    off  = int'($urandom_range(64)) - 32;
    if (dice < 25) return COORD_WIDTH'($urandom);
    if (dice < 55) return COORD_WIDTH'(int'(lo) + off);
    if (dice < 85) return COORD_WIDTH'(int'(hi) + off);
    return ($urandom_range(1) != 0) ? lo : hi;
  endfunction

  function automatic dist_result_t calc_distance(
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py
  );
    longint          x, y, lx, rx, by, ty, r, dx, dy, d;
    longint unsigned radicand, root, cand;
    pos_e            col, row;
    dist_result_t    res;
    x  = px;
    y  = py;
    lx = left_pole;
    rx = right_pole;
    by = bottom_pole;
    ty = top_pole;
    r  = longint'(radius);
    col = (x < lx) ? POS_BELOW : ((x < rx) ? POS_BETWEEN : POS_ABOVE);
    row = (y < by) ? POS_BELOW : ((y < ty) ? POS_BETWEEN : POS_ABOVE);
    if (col != POS_BETWEEN && row != POS_BETWEEN) begin
      dx = ((col == POS_BELOW) ? lx : rx) - x;
      dy = ((row == POS_BELOW) ? by : ty) - y;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      radicand = longint'(dx * dx + dy * dy) << (2 * FRAC_BITS);
      root = 0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= radicand) root = cand;
      end
      d = longint'(root) - (r <<< FRAC_BITS);
    end else if (row == POS_BETWEEN && col == POS_BELOW) begin
      d = (lx - x - r) <<< FRAC_BITS;
    end else if (row == POS_BETWEEN && col == POS_ABOVE) begin
      d = (x - rx - r) <<< FRAC_BITS;
    end else if (row == POS_BELOW) begin
      d = (by - y - r) <<< FRAC_BITS;
    end else if (row == POS_ABOVE) begin
      d = (y - ty - r) <<< FRAC_BITS;
    end else begin
      d = 0;
    end
    if (d > DIST_HI) d = DIST_HI;
    if (d < DIST_LO) d = DIST_LO;
    res.distance = DIST_WIDTH'(d);
    res.region   = REGION_WIDTH'(3 * int'(row) + int'(col));
    return res;
  endfunction

  // leaves valid high; whoever comes next lowers it or reuses it
  task automatic send_point(
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py,
    input int unsigned                   gap,
    input bit                            typed,
    input dist_result_t                  typed_res
  );
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    point_x  <= px;
    point_y  <= py;
    do @(posedge clk_i); while (in_stall);
    pending_results.push_back(typed ? typed_res : calc_distance(px, py));
  endtask

  task automatic write_reg(
    input logic [CFG_IDX_WIDTH-1:0] idx,
    input logic [COORD_WIDTH-1:0]   data
  );
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEFT_X:   left_pole   = data;
      CFG_RIGHT_X:  right_pole  = data;
      CFG_BOTTOM_Y: bottom_pole = data;
      CFG_TOP_Y:    top_pole    = data;
      CFG_RADIUS:   radius      = data[RAD_WIDTH-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // output side: stall runs alternate with free runs, some of them long
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run <= ($urandom_range(19) == 0) ? $urandom_range(300, 100)
                                              : $urandom_range(12);
    end else begin
      out_stall <= 1'b1;
      stall_run <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    dist_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: distance %0d region %0d",
               distance, region);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, distance);
          fail_count++;
        end
        if (region !== want.region) begin
          $error("region: expected %0d, got %0d", want.region, region);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic signed [COORD_WIDTH-1:0] lx, rx, by, ty, tmp;
    logic [RAD_WIDTH-1:0]          rad;
    dist_result_t                  typed_res;
    bit                            streaming;

    directed_rows = '{
      // registers at reset: all poles at the origin, no radius
      '{ROW_POINT, '0, 16'sd0, 16'sd0, TYPED, 22'sd0, REGION_UPPER_RIGHT},
      '{ROW_POINT, '0, -16'sd5, 16'sd0, TYPED, 22'sd80, REGION_UPPER_LEFT},
      '{ROW_POINT, '0, 16'sd3, -16'sd4, TYPED, 22'sd80, REGION_LOWER_RIGHT},
      '{ROW_POINT, '0, -16'sd32768, -16'sd32768, PREDICTED, '0, '0},
      '{ROW_WRITE, CFG_LEFT_X, -16'sd100, '0, PREDICTED, '0, '0},
      '{ROW_WRITE, CFG_RIGHT_X, 16'sd100, '0, PREDICTED, '0, '0},
      '{ROW_WRITE, CFG_BOTTOM_Y, -16'sd50, '0, PREDICTED, '0, '0},
      '{ROW_WRITE, CFG_TOP_Y, 16'sd50, '0, PREDICTED, '0, '0},
      // top bit of the radius write is dropped: radius becomes 10
      '{ROW_WRITE, CFG_RADIUS, 16'h800A, '0, PREDICTED, '0, '0},
      '{ROW_WRITE, IDX_SPARE_LO, 16'h1234, '0, PREDICTED, '0, '0},
      '{ROW_WRITE, IDX_SPARE_HI, 16'hFFFF, '0, PREDICTED, '0, '0},
      '{ROW_POINT, '0, 16'sd0, 16'sd0, TYPED, 22'sd0, REGION_INNER},
      '{ROW_POINT, '0, -16'sd100, -16'sd50, TYPED, 22'sd0, REGION_INNER},
      '{ROW_POINT, '0, 16'sd99, 16'sd49, TYPED, 22'sd0, REGION_INNER},
      '{ROW_POINT, '0, 16'sd100, 16'sd50, TYPED, -22'sd160, REGION_UPPER_RIGHT},
      '{ROW_POINT, '0, -16'sd101, 16'sd0, TYPED, -22'sd144, REGION_LEFT},
      '{ROW_POINT, '0, 16'sd120, 16'sd0, TYPED, 22'sd160, REGION_RIGHT},
      '{ROW_POINT, '0, 16'sd0, -16'sd60, TYPED, 22'sd0, REGION_BOTTOM},
      '{ROW_POINT, '0, 16'sd0, 16'sd70, TYPED, 22'sd160, REGION_TOP},
      '{ROW_POINT, '0, -16'sd103, -16'sd54, TYPED, -22'sd80, REGION_LOWER_LEFT},
      '{ROW_POINT, '0, 16'sd103, -16'sd54, TYPED, -22'sd80, REGION_LOWER_RIGHT},
      '{ROW_POINT, '0, -16'sd103, 16'sd54, TYPED, -22'sd80, REGION_UPPER_LEFT},
      '{ROW_POINT, '0, 16'sd32767, 16'sd32767, PREDICTED, '0, '0},
      '{ROW_POINT, '0, -16'sd32768, 16'sd32767, PREDICTED, '0, '0},
      '{ROW_POINT, '0, 16'sd32767, -16'sd32768, PREDICTED, '0, '0},
      '{ROW_POINT, '0, -16'sd32768, 16'sd0, PREDICTED, '0, '0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    streaming = 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].is_write) begin
        if (streaming) begin
          in_valid <= 1'b0;
          wait_idle();
          streaming = 1'b0;
        end
        write_reg(directed_rows[i].reg_idx, directed_rows[i].a);
      end else begin
        typed_res.distance = directed_rows[i].distance;
        typed_res.region   = directed_rows[i].region;
        send_point(directed_rows[i].a, directed_rows[i].b, pick_gap(),
                   directed_rows[i].typed, typed_res);
        streaming = 1'b1;
      end
    end
    in_valid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        // widest rectangle, largest radius
        lx = -16'sd32768; rx = 16'sd32767; by = -16'sd32768; ty = 16'sd32767;
        rad = '1;
      end else if (ph == 1) begin
        // fully crossed poles, no radius
        lx = 16'sd32767; rx = -16'sd32768; by = 16'sd32767; ty = -16'sd32768;
        rad = '0;
      end else begin
        lx  = COORD_WIDTH'($urandom);
        rx  = COORD_WIDTH'($urandom);
        by  = COORD_WIDTH'($urandom);
        ty  = COORD_WIDTH'($urandom);
        rad = RAD_WIDTH'($urandom);
        case (ph % 3)
          0: begin
            if (rx < lx) begin tmp = lx; lx = rx; rx = tmp; end
            if (ty < by) begin tmp = by; by = ty; ty = tmp; end
          end
          1: begin
            // small box, sometimes flat; may wrap into crossed poles
            rx  = ($urandom_range(3) == 0) ? lx : COORD_WIDTH'(lx + $urandom_range(300));
            ty  = ($urandom_range(3) == 0) ? by : COORD_WIDTH'(by + $urandom_range(300));
            rad = RAD_WIDTH'($urandom_range(200));
          end
          default: ;
        endcase
      end
      write_reg(CFG_LEFT_X, lx);
      write_reg(CFG_RIGHT_X, rx);
      write_reg(CFG_BOTTOM_Y, by);
      write_reg(CFG_TOP_Y, ty);
      write_reg(CFG_RADIUS, {1'($urandom_range(1)), rad});
      write_reg(CFG_IDX_WIDTH'($urandom_range(IDX_SPARE_HI, IDX_SPARE_LO)),
                COORD_WIDTH'($urandom));

      for (int n = 0; n < PHASE_POINTS; n++) begin
        if ($urandom_range(29) == 0) steady = !steady;
        send_point(pick_coord(lx, rx), pick_coord(by, ty),
                   steady ? 0 : pick_gap(), PREDICTED, '0);
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("rounded_rect_signed_distance_tb OK");
    end else begin
      $display("rounded_rect_signed_distance_tb NOT OK");
    end
    $finish;
  end

endmodule
